>>> hw/rtl/utv_pkg.sv
// utv_pkg: character codes, field positions and helper functions for the timestamp validator
`default_nettype none

package utv_pkg;

    typedef logic [7:0] char_t;
    typedef logic [4:0] pos_t;
    typedef logic [6:0] val2_t;

    localparam char_t CHAR_DASH  = 8'h2D;
    localparam char_t CHAR_COLON = 8'h3A;
    localparam char_t CHAR_T     = 8'h54;
    localparam char_t CHAR_Z     = 8'h5A;
    localparam char_t CHAR_ZERO  = 8'h30;
    localparam char_t CHAR_NINE  = 8'h39;

    // character positions within YYYY-MM-DDTHH:MM:SSZ
    localparam pos_t POS_YEAR_LO  = 5'd2;
    localparam pos_t POS_DASH1    = 5'd4;
    localparam pos_t POS_DASH2    = 5'd7;
    localparam pos_t POS_T        = 5'd10;
    localparam pos_t POS_COLON1   = 5'd13;
    localparam pos_t POS_COLON2   = 5'd16;
    localparam pos_t POS_Z        = 5'd19;
    localparam pos_t POS_LENGTH   = 5'd20;
    localparam pos_t POS_CAP      = 5'd21;

    localparam val2_t MONTH_FEB   = 7'd2;
    localparam val2_t MONTH_APR   = 7'd4;
    localparam val2_t MONTH_JUN   = 7'd6;
    localparam val2_t MONTH_SEP   = 7'd9;
    localparam val2_t MONTH_NOV   = 7'd11;
    localparam val2_t MONTH_MAX   = 7'd12;
    localparam val2_t HOUR_LIMIT  = 7'd24;
    localparam val2_t MIN_LIMIT   = 7'd60;

    // v * 10 + d, kept to seven bits
    function automatic val2_t acc2(input val2_t v, input logic [3:0] d);
        logic [9:0] sum;
        sum = ({3'b000, v} << 3) + ({3'b000, v} << 1) + {6'b000000, d};
        return sum[6:0];
    endfunction

    // days in a month, leap selects the long february
    function automatic logic [4:0] month_days(input val2_t m, input logic leap);
        logic [4:0] days;
        days = 5'd31;
        if (m == MONTH_FEB) begin
            days = leap ? 5'd29 : 5'd28;
        end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
                     m == MONTH_NOV) begin
            days = 5'd30;
        end
        return days;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/utc_timestamp_validator.sv
// utc_timestamp_validator: streaming check of YYYY-MM-DDTHH:MM:SSZ strings
// path: a final character passes the input register stage, then the result register
// throughput: one character per cycle, sustained, with results drained each cycle
// results: one per string, on the character flagged as end of string
// reset: aresetn is synchronous active low, empties both stages and restarts the parser
`default_nettype none

module utc_timestamp_validator (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_code,
    input  wire logic       s_end_of_string,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_timestamp_valid
);

    // input register stage
    logic                 in_valid_reg;
    utv_pkg::char_t       char_reg;
    logic                 last_reg;

    // parser state
    utv_pkg::pos_t        pos_reg,      pos_next;
    logic                 shape_ok_reg, shape_ok_next;
    // the year is held as two two-digit halves, which makes the leap test trivial
    utv_pkg::val2_t       year_hi_reg,  year_hi_next;
    utv_pkg::val2_t       year_lo_reg,  year_lo_next;
    utv_pkg::val2_t       month_reg,    month_next;
    utv_pkg::val2_t       day_reg,      day_next;
    utv_pkg::val2_t       hour_reg,     hour_next;
    utv_pkg::val2_t       minute_reg,   minute_next;
    utv_pkg::val2_t       second_reg,   second_next;

    // result register
    logic                 m_valid_reg;
    logic                 m_ts_valid_reg;

    logic                 advance;
    logic                 out_free;
    logic                 is_digit;
    logic [3:0]           digit;
    logic                 leap;
    logic [4:0]           days_in_month;
    logic                 result_ok;

    // result slot is free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;
    // a non-final character never needs the result slot
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    assign m_valid           = m_valid_reg;
    assign m_timestamp_valid = m_ts_valid_reg;

    // input stage: holds one transaction until the parser takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            char_reg <= s_char_code;
            last_reg <= s_end_of_string;
        end
    end

    assign is_digit = (char_reg >= utv_pkg::CHAR_ZERO) && (char_reg <= utv_pkg::CHAR_NINE);
    // ascii digits have their value in the low nibble
    assign digit    = char_reg[3:0];

    // next parser state for the character in the input stage
    always_comb begin
        pos_next      = pos_reg;
        shape_ok_next = shape_ok_reg;
        year_hi_next  = year_hi_reg;
        year_lo_next  = year_lo_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;

        priority if (pos_reg >= utv_pkg::POS_LENGTH) begin
            // too long
            shape_ok_next = 1'b0;
        end else if (pos_reg == utv_pkg::POS_DASH1 || pos_reg == utv_pkg::POS_DASH2) begin
            if (char_reg != utv_pkg::CHAR_DASH) shape_ok_next = 1'b0;
        end else if (pos_reg == utv_pkg::POS_T) begin
            if (char_reg != utv_pkg::CHAR_T) shape_ok_next = 1'b0;
        end else if (pos_reg == utv_pkg::POS_COLON1 || pos_reg == utv_pkg::POS_COLON2) begin
            if (char_reg != utv_pkg::CHAR_COLON) shape_ok_next = 1'b0;
        end else if (pos_reg == utv_pkg::POS_Z) begin
            if (char_reg != utv_pkg::CHAR_Z) shape_ok_next = 1'b0;
        end else if (!is_digit) begin
            // non-digit where a digit belongs, field left as it is
            shape_ok_next = 1'b0;
        end else if (pos_reg < utv_pkg::POS_YEAR_LO) begin
            year_hi_next = utv_pkg::acc2(year_hi_reg, digit);
        end else if (pos_reg < utv_pkg::POS_DASH1) begin
            year_lo_next = utv_pkg::acc2(year_lo_reg, digit);
        end else if (pos_reg < utv_pkg::POS_DASH2) begin
            month_next = utv_pkg::acc2(month_reg, digit);
        end else if (pos_reg < utv_pkg::POS_T) begin
            day_next = utv_pkg::acc2(day_reg, digit);
        end else if (pos_reg < utv_pkg::POS_COLON1) begin
            hour_next = utv_pkg::acc2(hour_reg, digit);
        end else if (pos_reg < utv_pkg::POS_COLON2) begin
            minute_next = utv_pkg::acc2(minute_reg, digit);
        end else begin
            second_next = utv_pkg::acc2(second_reg, digit);
        end

        // position counter saturates one past the full length
        if (pos_reg < utv_pkg::POS_CAP) begin
            pos_next = pos_reg + 5'd1;
        end
    end

    // gregorian leap rule on year = 100 * hi + lo: lo divisible by 4,
    // and lo nonzero or hi divisible by 4 (year zero counts as leap)
    assign leap = (year_lo_reg[1:0] == 2'b00) &&
                  ((year_lo_reg != 7'd0) || (year_hi_reg[1:0] == 2'b00));
    assign days_in_month = utv_pkg::month_days(month_reg, leap);

    // the closing 'Z' touches no field, so the stored values are final here
    assign result_ok = shape_ok_reg
                    && (pos_reg == utv_pkg::POS_Z)
                    && (char_reg == utv_pkg::CHAR_Z)
                    && (month_reg >= 7'd1) && (month_reg <= utv_pkg::MONTH_MAX)
                    && (day_reg >= 7'd1) && (day_reg <= {2'b00, days_in_month})
                    && (hour_reg < utv_pkg::HOUR_LIMIT)
                    && (minute_reg < utv_pkg::MIN_LIMIT)
                    && (second_reg < utv_pkg::MIN_LIMIT);

    // parser state, cleared after every final character
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && last_reg)) begin
            pos_reg      <= '0;
            shape_ok_reg <= 1'b1;
            year_hi_reg  <= '0;
            year_lo_reg  <= '0;
            month_reg    <= '0;
            day_reg      <= '0;
            hour_reg     <= '0;
            minute_reg   <= '0;
            second_reg   <= '0;
        end else if (advance) begin
            pos_reg      <= pos_next;
            shape_ok_reg <= shape_ok_next;
            year_hi_reg  <= year_hi_next;
            year_lo_reg  <= year_lo_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= advance && last_reg;
        end
        if (out_free && advance && last_reg) begin
            m_ts_valid_reg <= result_ok;
        end
    end

    // counter never passes its saturation value
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= utv_pkg::POS_CAP)
        else $error("position counter beyond saturation");

    // a final character always yields a pending result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_reg) |=> m_valid_reg)
        else $error("final character produced no result");

    // parser restarts after a final character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_reg) |=> (pos_reg == 5'd0 && shape_ok_reg))
        else $error("parser state not cleared after final character");

    // a pending final character waits only while the result slot is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && last_reg && !advance) |-> (m_valid_reg && !m_ready))
        else $error("final character stalled with free result slot");

endmodule

`default_nettype wire
